[hdl/fvws_pkg.sv]
// Shared constants, register codes and types for the four-voice wavetable synthesizer.
// Used by every module of the block but fvws_ram, and by its port checker.
package fvws_pkg;

   // Voices and phase accumulators.
   localparam int VOICES          = 4;
   localparam int VOICE_BITS      = $clog2(VOICES);
   localparam int PHASE_BITS      = 24;

   // Wave table: the top TABLE_ADDR_BITS phase bits address it.
   localparam int TABLE_ADDR_BITS = 8;
   localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
   localparam int INDEX_BITS      = 8;
   localparam int WAVE_BITS       = 8;

   // Mixing arithmetic.
   localparam int LEVEL_BITS      = 8;
   localparam int PROD_BITS       = WAVE_BITS + LEVEL_BITS;
   localparam int SUM_BITS        = PROD_BITS + VOICE_BITS;
   localparam int AUDIO_BITS      = 16;
   localparam int AUDIO_SHIFT     = 8;
   localparam int AUDIO_ADJ       = 6;

   // Configuration port.
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = PHASE_BITS;
   localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = '1;

   // Result buffer.
   localparam int OUT_DEPTH       = 4;
   localparam int OUT_PTR_BITS    = $clog2(OUT_DEPTH);
   localparam int OUT_COUNT_BITS  = $clog2(OUT_DEPTH + 1);

   // Request kinds carried on req_tuser.
   localparam logic REQ_SAMPLE      = 1'b0;
   localparam logic REQ_TABLE_WRITE = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_VOICE0_STEP  = 3'd0,
      REG_VOICE1_STEP  = 3'd1,
      REG_VOICE2_STEP  = 3'd2,
      REG_VOICE3_STEP  = 3'd3,
      REG_VOICE0_LEVEL = 3'd4,
      REG_VOICE1_LEVEL = 3'd5,
      REG_VOICE2_LEVEL = 3'd6,
      REG_VOICE3_LEVEL = 3'd7
   } csr_reg_type;

   // One issue slot from the sequencer into the datapath.
   typedef struct packed {
      logic                  valid;
      logic                  table_write;
      logic [VOICE_BITS-1:0] voice;
      logic                  last;
      logic [INDEX_BITS-1:0] index;
      logic [WAVE_BITS-1:0]  value;
   } issue_type;

endpackage

[hdl/fvws_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependency.
module fvws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/fvws_sequencer.sv]
// Request intake and slot sequencer: splits a sample request into one slot per voice.
// Depends on fvws_pkg; also keeps the result credit count.
module fvws_sequencer
   import fvws_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,
   input  logic [2*INDEX_BITS-1:0]   req_tdata,
   input  logic                      result_push,
   input  logic [OUT_COUNT_BITS-1:0] out_count,
   output issue_type                 issue
);

   logic                  busy_ff, busy_in;
   logic [VOICE_BITS-1:0] slot_ff, slot_in;
   logic                  write_ff, write_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;
   logic [WAVE_BITS-1:0]  value_ff, value_in;
   logic [OUT_COUNT_BITS-1:0] inflight_ff, inflight_in;
   logic [OUT_COUNT_BITS:0]   reserved;
   logic                  last_slot;
   logic                  accept;
   logic                  sample_accept;

   // A table write takes one slot, a sample takes one slot per voice.
   assign last_slot = write_ff || (slot_ff == VOICE_BITS'(VOICES - 1));

   // Samples accepted but not yet in the result buffer, plus what the buffer holds.
   assign reserved = {1'b0, inflight_ff} + {1'b0, out_count};

   assign req_tready    = (!busy_ff || last_slot) &&
                          (reserved < (OUT_COUNT_BITS + 1)'(OUT_DEPTH));
   assign accept        = req_tvalid && req_tready;
   assign sample_accept = accept && (req_tuser == REQ_SAMPLE);

   // Slot handed to the datapath this cycle.
   assign issue.valid       = busy_ff;
   assign issue.table_write = write_ff;
   assign issue.voice       = slot_ff;
   assign issue.last        = last_slot;
   assign issue.index       = index_ff;
   assign issue.value       = value_ff;

   // Next-state logic for the sequencer and the credit count.
   always_comb begin
      busy_in     = busy_ff;
      slot_in     = slot_ff;
      write_in    = write_ff;
      index_in    = index_ff;
      value_in    = value_ff;
      inflight_in = inflight_ff;
      if (accept) begin
         busy_in  = 1'b1;
         slot_in  = '0;
         write_in = req_tuser;
         index_in = req_tdata[INDEX_BITS-1:0];
         value_in = req_tdata[INDEX_BITS +: WAVE_BITS];
      end else if (busy_ff && last_slot) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         slot_in = slot_ff + 1'b1;
      end
      if (sample_accept && !result_push) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (!sample_accept && result_push) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         inflight_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         inflight_ff <= inflight_in;
      end
      slot_ff  <= slot_in;
      write_ff <= write_in;
      index_ff <= index_in;
      value_ff <= value_in;
   end

endmodule

[hdl/fvws_datapath.sv]
// Voice datapath: phase memory read-modify-write, wave table lookup, level multiply, mix.
// Depends on fvws_pkg and fvws_ram.
module fvws_datapath
   import fvws_pkg::*;
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  issue_type                              issue,
   input  logic [VOICES-1:0][PHASE_BITS-1:0]      voice_step,
   input  logic [VOICES-1:0][LEVEL_BITS-1:0]      voice_level,
   output logic                                   push,
   output logic [AUDIO_BITS-1:0]                  push_data
);

   // Stage 1: phase data back from memory.
   logic                  s1_valid_ff;
   logic                  s1_write_ff;
   logic                  s1_seen_ff;
   logic [VOICE_BITS-1:0] s1_voice_ff;
   logic                  s1_last_ff;
   logic [INDEX_BITS-1:0] s1_index_ff;
   logic [WAVE_BITS-1:0]  s1_value_ff;
   // Stage 2: table data back from memory.
   logic                  s2_valid_ff;
   logic [VOICE_BITS-1:0] s2_voice_ff;
   logic                  s2_last_ff;
   // Stage 3: product registered.
   logic                  s3_valid_ff;
   logic                  s3_first_ff;
   logic                  s3_last_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [SUM_BITS-1:0]   sum_in;

   logic [VOICES-1:0]     phase_valid_ff, phase_valid_in;
   logic [PHASE_BITS-1:0] phase_rdata;
   logic [PHASE_BITS-1:0] phase_old;
   logic [PHASE_BITS-1:0] phase_new;
   logic [WAVE_BITS-1:0]  wave_rdata;
   logic                  phase_re;
   logic                  phase_we;
   logic                  table_we;
   logic                  table_re;

   // Phase accumulators: read at issue, written back from stage 1 in the next cycle. The
   // other voices' slots lie between two reads of the same voice, so no forwarding is needed.
   assign phase_re = issue.valid && !issue.table_write;
   assign phase_we = s1_valid_ff && !s1_write_ff;

   fvws_ram #(
      .WIDTH (PHASE_BITS),
      .DEPTH (VOICES)
   ) u_phase_ram (
      .clock (clock),
      .we    (phase_we),
      .waddr (s1_voice_ff),
      .wdata (phase_new),
      .re    (phase_re),
      .raddr (issue.voice),
      .rdata (phase_rdata)
   );

   // An accumulator never written since reset reads as zero.
   assign phase_old = s1_seen_ff ? phase_rdata : '0;
   assign phase_new = phase_old + voice_step[s1_voice_ff];

   always_comb begin
      phase_valid_in = phase_valid_ff;
      if (phase_we) begin
         phase_valid_in[s1_voice_ff] = 1'b1;
      end
   end

   // Wave table: writes and lookups both happen in stage 1, in request order.
   assign table_we = s1_valid_ff && s1_write_ff;
   assign table_re = s1_valid_ff && !s1_write_ff;

   fvws_ram #(
      .WIDTH (WAVE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_wave_ram (
      .clock (clock),
      .we    (table_we),
      .waddr (TABLE_ADDR_BITS'(s1_index_ff)),
      .wdata (s1_value_ff),
      .re    (table_re),
      .raddr (phase_new[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
      .rdata (wave_rdata)
   );

   // Mix: the first voice of a sample restarts the sum.
   assign sum_in    = (s3_first_ff ? '0 : sum_ff) + SUM_BITS'(prod_ff);
   assign push      = s3_valid_ff && s3_last_ff;
   assign push_data = AUDIO_BITS'((sum_in >> AUDIO_SHIFT) << AUDIO_ADJ);

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         phase_valid_ff <= '0;
      end else begin
         s1_valid_ff    <= issue.valid;
         s2_valid_ff    <= table_re;
         s3_valid_ff    <= s2_valid_ff;
         phase_valid_ff <= phase_valid_in;
      end
      s1_write_ff <= issue.table_write;
      s1_seen_ff  <= phase_valid_ff[issue.voice];
      s1_voice_ff <= issue.voice;
      s1_last_ff  <= issue.last;
      s1_index_ff <= issue.index;
      s1_value_ff <= issue.value;
      s2_voice_ff <= s1_voice_ff;
      s2_last_ff  <= s1_last_ff;
      s3_first_ff <= (s2_voice_ff == '0);
      s3_last_ff  <= s2_last_ff;
      prod_ff     <= wave_rdata * voice_level[s2_voice_ff];
      if (s3_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

[hdl/fvws_out_buf.sv]
// Four-entry result buffer that drives the rsp_ stream.
// Depends on fvws_pkg.
module fvws_out_buf
   import fvws_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [AUDIO_BITS-1:0]     push_data,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [AUDIO_BITS-1:0]     rsp_tdata,
   output logic [OUT_COUNT_BITS-1:0] count
);

   logic [AUDIO_BITS-1:0]     entry_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]   wr_ptr_ff;
   logic [OUT_PTR_BITS-1:0]   rd_ptr_ff;
   logic [OUT_COUNT_BITS-1:0] count_ff, count_in;
   logic                      pop;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = entry_ff[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;
   assign count      = count_ff;

   // The sequencer's credit count keeps pushes within the buffer depth.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/four_voice_wavetable_synth.sv]
// Top level of the four-voice wavetable synthesizer: register file and submodule wiring.
// Depends on fvws_pkg, fvws_sequencer, fvws_datapath and fvws_out_buf.
//
// A sample request (req_tuser 0) takes one slot per voice: the voices share one read
// port of the phase memory and one read port of the wave table, so the next request
// is taken no sooner than the last voice slot, and only while the credit count shows
// room. A table write request (req_tuser 1) takes one slot and gives no result. The
// sample reaches rsp_ through the datapath stages, and a four-entry result buffer lets
// new requests enter while results wait. Table entries must be written before a sample
// reads them. Registers must be written on csr_ only while no request is in flight,
// which the block does not enforce; steps (indexes 0 to 3) reset to zero, levels to 255.
module four_voice_wavetable_synth
   import fvws_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Request stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*INDEX_BITS-1:0]   req_tdata,  // table_index [7:0], table_value [15:8]
   input  logic                      req_tuser,  // req_type [0]
   // Result stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [AUDIO_BITS-1:0]     rsp_tdata,  // audio_sample [15:0]
   // Register write port.
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [VOICES-1:0][PHASE_BITS-1:0] step_ff, step_in;
   logic [VOICES-1:0][LEVEL_BITS-1:0] level_ff, level_in;
   issue_type                         issue;
   logic                              push;
   logic [AUDIO_BITS-1:0]             push_data;
   logic [OUT_COUNT_BITS-1:0]         out_count;

   // Register write decode.
   always_comb begin
      step_in  = step_ff;
      level_in = level_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_VOICE0_STEP:  step_in[0]  = csr_wdata[PHASE_BITS-1:0];
            REG_VOICE1_STEP:  step_in[1]  = csr_wdata[PHASE_BITS-1:0];
            REG_VOICE2_STEP:  step_in[2]  = csr_wdata[PHASE_BITS-1:0];
            REG_VOICE3_STEP:  step_in[3]  = csr_wdata[PHASE_BITS-1:0];
            REG_VOICE0_LEVEL: level_in[0] = csr_wdata[LEVEL_BITS-1:0];
            REG_VOICE1_LEVEL: level_in[1] = csr_wdata[LEVEL_BITS-1:0];
            REG_VOICE2_LEVEL: level_in[2] = csr_wdata[LEVEL_BITS-1:0];
            REG_VOICE3_LEVEL: level_in[3] = csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         level_ff <= {VOICES{LEVEL_RESET}};
      end else begin
         step_ff  <= step_in;
         level_ff <= level_in;
      end
   end

   fvws_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .result_push (push),
      .out_count   (out_count),
      .issue       (issue)
   );

   fvws_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .voice_step  (step_ff),
      .voice_level (level_ff),
      .push        (push),
      .push_data   (push_data)
   );

   fvws_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .count      (out_count)
   );

endmodule

[hdl/fvws_checker.sv]
// Port-level checks for the four-voice wavetable synthesizer, bound to its top level.
// Depends on fvws_pkg and four_voice_wavetable_synth.
module fvws_checker
   import fvws_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [2*INDEX_BITS-1:0]   req_tdata,
   input logic                      req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [AUDIO_BITS-1:0]     rsp_tdata,
   input logic                      csr_we,
   input logic [CSR_INDEX_BITS-1:0] csr_index,
   input logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The mix is left-adjusted, so the low bits of every sample are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[AUDIO_ADJ-1:0] == '0))
      else $error("sample low bits not zero");

   // A sample request occupies the voice slots, so the next cycle takes no request.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_SAMPLE) |=> !req_tready)
      else $error("request taken during voice slots");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind four_voice_wavetable_synth fvws_checker u_fvws_checker (.*);

[tb/sv/four_voice_wavetable_synth_tb.sv]
// Self-checking testbench for the four-voice wavetable synthesizer.
// It predicts each audio sample from its own copy of the voices and the wave table.
// Depends on fvws_pkg and four_voice_wavetable_synth.
module four_voice_wavetable_synth_tb;
   import fvws_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASE_ITEMS    = 200;

   // How a phase sets the voice registers.
   localparam int CFG_RANDOM = 0;
   localparam int CFG_FAST   = 1;
   localparam int CFG_STILL  = 2;

   // One request as the driver sends it; hold makes the driver wait for all samples.
   typedef struct {
      logic                  kind;
      logic [INDEX_BITS-1:0] index;
      logic [WAVE_BITS-1:0]  value;
      bit                    hold;
   } synth_req_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [2*INDEX_BITS-1:0]   req_tdata = '0;  // table_index [7:0], table_value [15:8]
   logic                      req_tuser = REQ_SAMPLE;  // req_type [0]
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [AUDIO_BITS-1:0]     rsp_tdata;  // audio_sample [15:0]
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Predicted block state.
   logic [PHASE_BITS-1:0] voice_step  [VOICES];
   logic [LEVEL_BITS-1:0] voice_level [VOICES];
   logic [PHASE_BITS-1:0] voice_phase [VOICES];
   logic [WAVE_BITS-1:0]  tone_table  [TABLE_DEPTH];

   // Planning state: where the accumulators will be once the queue has drained,
   // and which table entries will have been written by then.
   logic [PHASE_BITS-1:0] plan_phase  [VOICES];
   bit                    plan_loaded [TABLE_DEPTH];

   synth_req_type         req_queue[$];
   logic [AUDIO_BITS-1:0] pending_samples[$];
   synth_req_type         on_bus;
   int                    error_count = 0;
   int                    max_gap = 3;
   int                    send_gap = 0;
   int                    recv_stall = 0;
   int                    quiet_cycles = 0;

   four_voice_wavetable_synth u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one accepted request to the predicted state; a sample request yields
   // the mix of the four voices after their accumulators advance.
   function automatic void apply_request(synth_req_type r);
      logic [SUM_BITS-1:0]        mix;
      logic [TABLE_ADDR_BITS-1:0] addr;
      if (r.kind == REQ_TABLE_WRITE) begin
         tone_table[r.index[TABLE_ADDR_BITS-1:0]] = r.value;
      end else begin
         mix = '0;
         for (int v = 0; v < VOICES; v++) begin
            voice_phase[v] = voice_phase[v] + voice_step[v];
            addr = voice_phase[v][PHASE_BITS-1 -: TABLE_ADDR_BITS];
            mix = mix + tone_table[addr] * voice_level[v];
         end
         pending_samples.push_back(AUDIO_BITS'((mix >> AUDIO_SHIFT) << AUDIO_ADJ));
      end
   endfunction

   function automatic void queue_write(logic [INDEX_BITS-1:0] index,
                                       logic [WAVE_BITS-1:0] value);
      synth_req_type r;
      r.kind  = REQ_TABLE_WRITE;
      r.index = index;
      r.value = value;
      r.hold  = ($urandom_range(0, 149) == 0);
      plan_loaded[index[TABLE_ADDR_BITS-1:0]] = 1'b1;
      req_queue.push_back(r);
   endfunction

   // Queue a sample request, first loading any table entry it would read unwritten.
   function automatic void queue_sample(logic [2*INDEX_BITS-1:0] noise, bit hold);
      synth_req_type              r;
      logic [TABLE_ADDR_BITS-1:0] addr;
      for (int v = 0; v < VOICES; v++) begin
         plan_phase[v] = plan_phase[v] + voice_step[v];
         addr = plan_phase[v][PHASE_BITS-1 -: TABLE_ADDR_BITS];
         if (!plan_loaded[addr]) begin
            queue_write(INDEX_BITS'(addr), WAVE_BITS'($urandom_range(0, 255)));
         end
      end
      r.kind  = REQ_SAMPLE;
      r.index = noise[INDEX_BITS-1:0];
      r.value = noise[2*INDEX_BITS-1:INDEX_BITS];
      r.hold  = hold || ($urandom_range(0, 149) == 0);
      req_queue.push_back(r);
   endfunction

   task automatic write_reg(csr_reg_type reg_id, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_id;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (reg_id <= REG_VOICE3_STEP) begin
         voice_step[reg_id - REG_VOICE0_STEP] = data;
      end else begin
         voice_level[reg_id - REG_VOICE0_LEVEL] = data[LEVEL_BITS-1:0];
      end
   endtask

   // Wait until every queued request is accepted and every sample has arrived,
   // then give a trailing table write time to finish inside the block.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (req_queue.size() != 0 || req_tvalid || pending_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_voices(int mode);
      logic [CSR_DATA_BITS-1:0] data;
      for (int v = 0; v < VOICES; v++) begin
         case (mode)
            CFG_FAST:  data = '1;
            CFG_STILL: data = '0;
            default: begin
               case ($urandom_range(0, 5))
                  0:       data = '0;
                  1:       data = '1;
                  2:       data = CSR_DATA_BITS'($urandom_range(1, 255));
                  3:       data = {8'($urandom_range(0, 255)), 16'h0000};
                  default: data = CSR_DATA_BITS'($urandom);
               endcase
            end
         endcase
         write_reg(csr_reg_type'(REG_VOICE0_STEP + v), data);
      end
      for (int v = 0; v < VOICES; v++) begin
         case (mode)
            CFG_FAST:  data = '1;
            CFG_STILL: data = '0;
            default: begin
               case ($urandom_range(0, 3))
                  0:       data = '0;
                  1:       data = CSR_DATA_BITS'(LEVEL_RESET);
                  2:       data = CSR_DATA_BITS'($urandom);
                  default: data = CSR_DATA_BITS'($urandom_range(0, 255));
               endcase
            end
         endcase
         write_reg(csr_reg_type'(REG_VOICE0_LEVEL + v), data);
      end
   endtask

   // Request driver: one transfer per item, a random gap after each.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(on_bus);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap   = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (req_queue.size() != 0 &&
                         !(req_queue[0].hold && pending_samples.size() != 0)) begin
               on_bus = req_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_bus.value, on_bus.index};
               req_tuser  <= on_bus.kind;
               send_gap   = $urandom_range(0, max_gap);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Sample monitor: compares each transfer with the oldest predicted sample.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_samples.size() == 0) begin
               $error("audio_sample: unexpected transfer, actual %0d", rsp_tdata);
               error_count++;
            end else if (rsp_tdata !== pending_samples[0]) begin
               $error("audio_sample: expected %0d, actual %0d", pending_samples[0], rsp_tdata);
               error_count++;
               void'(pending_samples.pop_front());
            end else begin
               void'(pending_samples.pop_front());
            end
            recv_stall = $urandom_range(0, max_gap);
         end else if (recv_stall != 0) begin
            recv_stall = recv_stall - 1;
         end
         rsp_tready <= (recv_stall == 0);
      end
   end

   // Watchdog on cycles without any transfer on either stream.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[four_voice_wavetable_synth] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed checks first, then random phases under varied settings.
   initial begin
      for (int v = 0; v < VOICES; v++) begin
         voice_step[v]  = '0;
         voice_level[v] = LEVEL_RESET;
         voice_phase[v] = '0;
         plan_phase[v]  = '0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tone_table[i]  = '0;
         plan_loaded[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: all voices sit on entry zero at full level.
      queue_write(8'h00, 8'hFF);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      queue_write(8'h00, 8'h00);
      queue_sample(16'h5AA5, 1'b0);
      queue_write(8'hFF, 8'h00);
      queue_write(8'h00, 8'h80);
      queue_sample(16'h0000, 1'b0);
      wait_idle();

      // Wrapping, whole-entry, half-turn and tiny steps; level data above bit 7 is dropped.
      write_reg(REG_VOICE0_STEP, 24'hFFFFFF);
      write_reg(REG_VOICE1_STEP, 24'h010000);
      write_reg(REG_VOICE2_STEP, 24'h800000);
      write_reg(REG_VOICE3_STEP, 24'h000001);
      write_reg(REG_VOICE0_LEVEL, 24'h0000FF);
      write_reg(REG_VOICE1_LEVEL, 24'hFFFF00);
      write_reg(REG_VOICE2_LEVEL, 24'h000080);
      write_reg(REG_VOICE3_LEVEL, 24'h000001);
      queue_write(8'hFF, 8'hFF);
      for (int i = 0; i < 4; i++) begin
         queue_sample(16'($urandom), 1'b0);
      end
      wait_idle();

      // Largest possible mix on every voice.
      set_voices(CFG_FAST);
      queue_write(8'hFE, 8'hFF);
      queue_write(8'hFD, 8'hFF);
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0000, 1'b0);
      wait_idle();

      // Random phases; one runs with no idling on either side.
      for (int p = 0; p < 8; p++) begin
         max_gap = (p == 5) ? 0 : 3;
         set_voices(p == 0 ? CFG_FAST : (p == 3 ? CFG_STILL : CFG_RANDOM));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               queue_write(INDEX_BITS'($urandom_range(0, 255)),
                           WAVE_BITS'($urandom_range(0, 255)));
            end else begin
               queue_sample(16'($urandom), i == PHASE_ITEMS / 2);
            end
         end
         wait_idle();
      end

      if (error_count == 0 && pending_samples.size() == 0) begin
         $display("[four_voice_wavetable_synth] OK");
      end else begin
         $display("[four_voice_wavetable_synth] ERROR");
      end
      $finish;
   end

endmodule
